// ===== sv/swlmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlmf_pkg
// shared widths, constants and the queue item type of the label mode filter
// ----------------------------------------------------------------------------
package swlmf_pkg;

  localparam int LABEL_W     = 4;
  localparam int COUNT_W     = 7;
  localparam int STAMP_W     = 8;
  localparam int WLEN_W      = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd60;

  typedef logic [LABEL_W-1:0] label_t;

  // one classified label on its way from the front to the back
  typedef struct packed {
    label_t label;
    logic   drop;
    label_t old_label;
  } item_t;

endpackage

// ===== sv/swlmf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlmf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module swlmf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/swlmf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlmf_front
// accepts labels, keeps the label ring and decides which label leaves the window
// ----------------------------------------------------------------------------
module swlmf_front import swlmf_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int NUM_CLASSES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              label_valid,
  input  label_t            label,
  output logic              label_stall,
  input  logic [WLEN_W-1:0] wlen,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output item_t             push_item
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = ((FILL_W > WLEN_W) ? FILL_W : WLEN_W) + 1;
  localparam int SUM_W  = FILL_W + 2;
  localparam int LABELS = 2 ** LABEL_W;

  typedef logic [LABELS-1:0][LABEL_W-1:0] label_map_t;

  function automatic label_map_t build_label_map();
    label_map_t m;
    for (int i = 0; i < LABELS; i++) begin
      m[i] = LABEL_W'(i % NUM_CLASSES);
    end
    return m;
  endfunction

  localparam label_map_t LABEL_MAP = build_label_map();

  logic [PTR_W-1:0]  write_slot, write_slot_next, oldest_slot;
  logic [FILL_W-1:0] fill, fill_next;
  logic [CMP_W-1:0]  win_eff;
  logic [SUM_W-1:0]  oldest_sum, oldest_wrap;
  logic              drop, accept, space;
  label_t            lab, ram_rdata;
  logic              s1_valid, s1_drop;
  label_t            s1_label;

  always_comb begin
    lab = LABEL_MAP[label];
    if (wlen == '0) begin
      win_eff = CMP_W'(1);
    end else if (CMP_W'(wlen) > CMP_W'(MAX_WINDOW)) begin
      win_eff = CMP_W'(MAX_WINDOW);
    end else begin
      win_eff = CMP_W'(wlen);
    end
    drop = (CMP_W'(fill) + CMP_W'(1)) > win_eff;

    oldest_sum = SUM_W'(write_slot) + SUM_W'(MAX_WINDOW) - SUM_W'(fill);
    if (oldest_sum >= SUM_W'(MAX_WINDOW)) begin
      oldest_wrap = oldest_sum - SUM_W'(MAX_WINDOW);
    end else begin
      oldest_wrap = oldest_sum;
    end
    oldest_slot = PTR_W'(oldest_wrap);

    write_slot_next = (write_slot == PTR_W'(MAX_WINDOW - 1)) ? '0 : write_slot + PTR_W'(1);
    fill_next       = drop ? fill : fill + FILL_W'(1);

    // room for the item still in the read stage plus the new one
    space       = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid)) <
                  (QCNT_W + 1)'(QUEUE_DEPTH);
    label_stall = !space;
    accept      = label_valid && space;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill       <= '0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        write_slot <= write_slot_next;
        fill       <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_label <= lab;
      s1_drop  <= drop;
    end
  end

  swlmf_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (write_slot),
    .wdata (lab),
    .raddr (oldest_slot),
    .rdata (ram_rdata)
  );

  assign push                = s1_valid;
  assign push_item.label     = s1_label;
  assign push_item.drop      = s1_drop;
  assign push_item.old_label = ram_rdata;

endmodule

// ===== sv/swlmf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlmf_queue
// short fifo of classified labels between front and back
// ----------------------------------------------------------------------------
module swlmf_queue import swlmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  item_t             push_item,
  input  logic              pop,
  output item_t             head_item,
  output logic [QCNT_W-1:0] count
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;

  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/swlmf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlmf_back
// per-class counts and recency, argmax tree and result register
// ----------------------------------------------------------------------------
module swlmf_back import swlmf_pkg::*; #(
  parameter int NUM_CLASSES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [QCNT_W-1:0]  q_count,
  input  item_t              head_item,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output label_t             smoothed_label,
  output logic [COUNT_W-1:0] winning_count
);

  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int LEVELS = CLS_W;
  localparam int LEAVES = 2 ** CLS_W;
  localparam int KEY_W  = COUNT_W + STAMP_W;

  logic [COUNT_W-1:0]   counts    [NUM_CLASSES];
  logic [COUNT_W-1:0]   cnt_next  [NUM_CLASSES];
  logic [STAMP_W-1:0]   last_seen [NUM_CLASSES];
  logic [STAMP_W-1:0]   seen_next [NUM_CLASSES];
  logic [STAMP_W-1:0]   frame_stamp;
  logic [NUM_CLASSES-1:0] hit_new, hit_old;
  logic [KEY_W-1:0]     tkey [LEVELS+1][LEAVES];
  logic [CLS_W-1:0]     tidx [LEVELS+1][LEAVES];
  logic [STAMP_W-1:0]   age;

  assign pop = (q_count != '0) && (!result_valid || !result_stall);

  always_comb begin
    tkey = '{default: '0};
    tidx = '{default: '0};
    age  = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      hit_new[c]   = (c == int'(head_item.label));
      hit_old[c]   = head_item.drop && (c == int'(head_item.old_label)) && (counts[c] != '0);
      cnt_next[c]  = counts[c] + COUNT_W'(hit_new[c]) - COUNT_W'(hit_old[c]);
      seen_next[c] = hit_new[c] ? frame_stamp : last_seen[c];
    end
    // key is count first, then newer beats older
    for (int c = 0; c < LEAVES; c++) begin
      tidx[0][c] = CLS_W'(c);
      if (c < NUM_CLASSES) begin
        age        = frame_stamp - seen_next[c];
        tkey[0][c] = {cnt_next[c], ~age};
      end
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int n = 0; n < LEAVES / 2; n++) begin
        if (n < (LEAVES >> (l + 1))) begin
          if (tkey[l][2*n+1] > tkey[l][2*n]) begin
            tkey[l+1][n] = tkey[l][2*n+1];
            tidx[l+1][n] = tidx[l][2*n+1];
          end else begin
            tkey[l+1][n] = tkey[l][2*n];
            tidx[l+1][n] = tidx[l][2*n];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      frame_stamp  <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        counts[c]    <= '0;
        last_seen[c] <= '0;
      end
    end else begin
      if (pop) begin
        result_valid <= 1'b1;
        frame_stamp  <= frame_stamp + STAMP_W'(1);
        counts       <= cnt_next;
        last_seen    <= seen_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      smoothed_label <= LABEL_W'(tidx[LEVELS][0]);
      winning_count  <= tkey[LEVELS][0][KEY_W-1 -: COUNT_W];
    end
  end

endmodule

// ===== sv/sliding_window_label_mode_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_label_mode_filter
// majority vote over the most recent class labels, ties to the newest class
// ----------------------------------------------------------------------------
// usage
//   label channel: label_valid / label_stall, one class code per transaction
//   result channel: result_valid / result_stall, smoothed_label and
//   winning_count, exactly one result transaction per label transaction
//   config channel: cfg_valid / cfg_ready with window_length, always ready;
//   write it only while no label is in flight
// path: a taken label passes the ring read stage and the queue; the back end
//   then pops it and registers its result
// throughput: one label per cycle while label_stall is low; the back end updates
//   all class counters and runs the argmax tree combinationally per transaction
// receiver stall: the result register holds; labels keep flowing into the
//   four-entry queue, and label_stall rises once the queue and the ring read
//   stage together hold four labels
// reset: window empty, all counts and recency stamps zero, window_length 60;
//   the label ring needs no clearing since only entries inside the window
//   are ever read
// ----------------------------------------------------------------------------
module sliding_window_label_mode_filter import swlmf_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int NUM_CLASSES = 16
) (
  input  logic               clk,
  input  logic               rst,
  // label input
  input  logic               label_valid,
  output logic               label_stall,
  input  logic [3:0]         label,
  // result output
  output logic               result_valid,
  input  logic               result_stall,
  output logic [3:0]         smoothed_label,
  output logic [6:0]         winning_count,
  // window length register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         window_length
);

  logic [WLEN_W-1:0] wlen;
  logic [QCNT_W-1:0] q_count;
  logic              push, pop;
  item_t             push_item, head_item;

  // config register, taken on any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= WLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wlen <= window_length;
    end
  end

  // front: label ring, fill level, oldest-label lookup
  swlmf_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .label_valid (label_valid),
    .label       (label),
    .label_stall (label_stall),
    .wlen        (wlen),
    .q_count     (q_count),
    .push        (push),
    .push_item   (push_item)
  );

  // decoupling queue
  swlmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .count     (q_count)
  );

  // back: counters, recency and winner selection
  swlmf_back #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_count        (q_count),
    .head_item      (head_item),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .smoothed_label (smoothed_label),
    .winning_count  (winning_count)
  );

endmodule
